@@ hdl/abs_pkg.sv @@
// ----------------------------------------------------------------------------
// abs_pkg
// Shared types and constants of the alternating-bit sender: action and outcome
// codes, checksum limits, the fixed acknowledgement pattern and the control
// structs between the core and the payload buffer.
// ----------------------------------------------------------------------------
package abs_pkg;

  // Input action codes.
  localparam logic [1:0] ACT_MSG  = 2'd0;
  localparam logic [1:0] ACT_ACK  = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;

  // Outcome codes carried by result items.
  localparam logic [2:0] OUT_OK        = 3'd0;
  localparam logic [2:0] OUT_WRONG_PH  = 3'd1;
  localparam logic [2:0] OUT_NOT_ACK   = 3'd2;
  localparam logic [2:0] OUT_BAD_SUM   = 3'd3;
  localparam logic [2:0] OUT_WRONG_BIT = 3'd4;
  localparam logic [2:0] OUT_RESEND    = 3'd5;

  // Saturation limits of the running checksum.
  localparam logic signed [12:0] SUM_MAX = 13'sd4095;
  localparam logic signed [12:0] SUM_MIN = -13'sd4096;

  // Retransmit timeout after reset.
  localparam logic [15:0] TIMEOUT_RESET = 16'd20;

  // Byte values of the acknowledgement pattern.
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_ONE  = 8'h31;

  // Request from the core to the payload buffer.
  typedef struct packed {
    logic start;  // begin reading the stored packet from entry zero
    logic take;   // the byte on offer moves to the output register
  } abs_rd_ctrl_t;

  // Byte on offer from the payload buffer.
  typedef struct packed {
    logic       valid;
    logic       last;
    logic [7:0] data;
  } abs_rd_stat_t;

  // Expected acknowledgement byte at a given frame position: nineteen zeros,
  // a one, two zeros, then zero bytes.
  function automatic logic [7:0] ack_pattern_byte(input logic [6:0] pos);
    logic [7:0] val;
    if (pos < 7'd19) begin
      val = CHAR_ZERO;
    end else if (pos == 7'd19) begin
      val = CHAR_ONE;
    end else if (pos < 7'd22) begin
      val = CHAR_ZERO;
    end else begin
      val = 8'h00;
    end
    return val;
  endfunction

endpackage

@@ hdl/alternating_bit_sender_core.sv @@
// ----------------------------------------------------------------------------
// alternating_bit_sender_core
// Stop-and-wait alternating-bit sender: gathers frames, sends and resends the
// stored packet from the payload memory, and checks acknowledgements.
// ----------------------------------------------------------------------------
// A status result is registered and appears in the cycle after its input
// transfer; the first packet byte passes the sequencer start, the memory read
// and the output register. One input per cycle while no packet is sent and the
// output is free; a packet streams its PAYLOAD_BYTES results one per cycle,
// paced by out_ready, and no input is taken until its last byte is taken.
// Reset: phase waits for call zero, timer off, timeout 20 ticks, assembler cleared.
// ----------------------------------------------------------------------------
module alternating_bit_sender_core #(
  parameter int PAYLOAD_BYTES = 20
) (
  input  logic               clk,
  input  logic               rst,
  // Configuration
  input  logic               cfg_write,
  input  logic [15:0]        cfg_data,
  // Input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         action,
  input  logic signed [7:0]  data_byte,
  input  logic signed [31:0] ack_number,
  input  logic signed [31:0] ack_checksum,
  // Result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic               is_packet_byte,
  output logic               packet_seq,
  output logic signed [12:0] packet_checksum,
  output logic signed [7:0]  packet_byte,
  output logic               packet_last,
  output logic [2:0]         outcome
);

  localparam int AW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SEND = 1'b1;

  logic               state;
  logic [1:0]         phase;
  logic [AW-1:0]      byte_count;
  logic signed [12:0] running_sum;
  logic signed [12:0] saved_checksum;
  logic               pattern_match;
  logic               timer_running;
  logic [15:0]        timer_remaining;
  logic [15:0]        timeout_ticks;
  logic [2:0]         send_outcome;

  logic                  accept;
  logic                  is_data;
  logic                  ack_phase;
  logic                  frame_done;
  logic signed [13:0]    sum_wide;
  logic signed [12:0]    sum_sat;
  logic                  pm_next;
  logic                  out_free;
  logic                  start_send;
  logic [2:0]            status_code;
  logic                  status_emit;
  abs_pkg::abs_rd_ctrl_t rd_ctrl;
  abs_pkg::abs_rd_stat_t rd_stat;

  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE) && out_free;
  assign accept    = in_valid && in_ready;
  assign is_data   = (action == abs_pkg::ACT_MSG) || (action == abs_pkg::ACT_ACK);
  assign ack_phase = phase[0];
  assign frame_done = (byte_count == AW'(PAYLOAD_BYTES - 1));

  // Saturating running checksum with the incoming byte added.
  assign sum_wide = {running_sum[12], running_sum} + {{6{data_byte[7]}}, data_byte};
  always_comb begin
    if (sum_wide[13] != sum_wide[12]) begin
      sum_sat = sum_wide[13] ? abs_pkg::SUM_MIN : abs_pkg::SUM_MAX;
    end else begin
      sum_sat = sum_wide[12:0];
    end
  end

  assign pm_next = pattern_match &&
                   (abs_pkg::ack_pattern_byte(7'(byte_count)) == data_byte);

  // Decide what a transfer produces: a packet, one status item, or nothing.
  always_comb begin
    start_send  = 1'b0;
    status_emit = 1'b0;
    status_code = abs_pkg::OUT_OK;
    if (accept && is_data && frame_done) begin
      if (action == abs_pkg::ACT_MSG) begin
        if (ack_phase) begin
          status_emit = 1'b1;
          status_code = abs_pkg::OUT_WRONG_PH;
        end else begin
          start_send = 1'b1;
        end
      end else begin
        status_emit = 1'b1;
        if (!ack_phase) begin
          status_code = abs_pkg::OUT_WRONG_PH;
        end else if (!pm_next) begin
          status_code = abs_pkg::OUT_NOT_ACK;
        end else if ({{19{sum_sat[12]}}, sum_sat} != ack_checksum) begin
          status_code = abs_pkg::OUT_BAD_SUM;
        end else if (ack_number != {31'd0, phase[1]}) begin
          status_code = abs_pkg::OUT_WRONG_BIT;
        end else begin
          status_code = abs_pkg::OUT_OK;
        end
      end
    end else if (accept && (action == abs_pkg::ACT_TICK) && timer_running &&
                 (timer_remaining <= 16'd1) && ack_phase) begin
      start_send = 1'b1;
    end
  end

  assign rd_ctrl.start = start_send;
  assign rd_ctrl.take  = (state == ST_SEND) && rd_stat.valid && out_free;

  abs_payload_buf #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_buf (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept && is_data && !ack_phase),
    .wr_addr (byte_count),
    .wr_data (data_byte),
    .ctrl    (rd_ctrl),
    .stat    (rd_stat)
  );

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= abs_pkg::TIMEOUT_RESET;
    end else if (cfg_write) begin
      timeout_ticks <= cfg_data;
    end
  end

  // Protocol state: assembler, phase, timer and sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      phase           <= 2'd0;
      byte_count      <= '0;
      running_sum     <= '0;
      saved_checksum  <= '0;
      pattern_match   <= 1'b1;
      timer_running   <= 1'b0;
      timer_remaining <= '0;
      send_outcome    <= abs_pkg::OUT_OK;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept && is_data) begin
            if (frame_done) begin
              byte_count    <= '0;
              running_sum   <= '0;
              pattern_match <= 1'b1;
              if (start_send) begin
                saved_checksum  <= sum_sat;
                timer_running   <= 1'b1;
                timer_remaining <= timeout_ticks;
                phase[0]        <= 1'b1;
                send_outcome    <= abs_pkg::OUT_OK;
                state           <= ST_SEND;
              end else if ((action == abs_pkg::ACT_ACK) &&
                           (status_code == abs_pkg::OUT_OK)) begin
                timer_running   <= 1'b0;
                timer_remaining <= '0;
                phase           <= phase + 2'd1;
              end
            end else begin
              byte_count    <= byte_count + 1'b1;
              running_sum   <= sum_sat;
              pattern_match <= pm_next;
            end
          end else if (accept && (action == abs_pkg::ACT_TICK) && timer_running) begin
            if (timer_remaining > 16'd1) begin
              timer_remaining <= timer_remaining - 16'd1;
            end else if (!ack_phase) begin
              timer_running   <= 1'b0;
              timer_remaining <= '0;
            end else begin
              timer_remaining <= timeout_ticks;
              send_outcome    <= abs_pkg::OUT_RESEND;
              state           <= ST_SEND;
            end
          end
        end
        ST_SEND: begin
          if (rd_ctrl.take && rd_stat.last) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register: packet bytes from the buffer, or one status item.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rd_ctrl.take || status_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_ctrl.take) begin
      is_packet_byte  <= 1'b1;
      packet_seq      <= phase[1];
      packet_checksum <= saved_checksum;
      packet_byte     <= rd_stat.data;
      packet_last     <= rd_stat.last;
      outcome         <= send_outcome;
    end else if (status_emit) begin
      is_packet_byte  <= 1'b0;
      packet_seq      <= 1'b0;
      packet_checksum <= '0;
      packet_byte     <= '0;
      packet_last     <= 1'b1;
      outcome         <= status_code;
    end
  end

endmodule

@@ hdl/abs_payload_buf.sv @@
// ----------------------------------------------------------------------------
// abs_payload_buf
// Packet payload memory with one write port and a synchronous read port, and
// the read sequencer that streams the packet one byte per cycle while taken.
// ----------------------------------------------------------------------------
module abs_payload_buf #(
  parameter int PAYLOAD_BYTES = 20,
  localparam int AW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  logic [7:0]            wr_data,
  input  abs_pkg::abs_rd_ctrl_t ctrl,
  output abs_pkg::abs_rd_stat_t stat
);

  logic [7:0]    mem [PAYLOAD_BYTES];
  logic [AW-1:0] rd_idx;
  logic          issuing;
  logic          issue;
  logic          rd_valid;
  logic          rd_last;
  logic [7:0]    rd_data;

  // A new read goes out when the data register is empty or is being emptied.
  assign issue = issuing && (!rd_valid || ctrl.take);

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_data <= mem[rd_idx];
    end
  end

  // Read sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      issuing  <= 1'b0;
      rd_idx   <= '0;
      rd_valid <= 1'b0;
      rd_last  <= 1'b0;
    end else begin
      if (ctrl.start) begin
        issuing <= 1'b1;
        rd_idx  <= '0;
      end else if (issue) begin
        if (rd_idx == AW'(PAYLOAD_BYTES - 1)) begin
          issuing <= 1'b0;
        end
        rd_idx <= rd_idx + 1'b1;
      end
      if (issue) begin
        rd_valid <= 1'b1;
        rd_last  <= (rd_idx == AW'(PAYLOAD_BYTES - 1));
      end else if (ctrl.take) begin
        rd_valid <= 1'b0;
      end
    end
  end

  assign stat.valid = rd_valid;
  assign stat.last  = rd_last;
  assign stat.data  = rd_data;

endmodule
